// ===== rtl/seed_record_stream_parser_unit_defines.svh =====
// Assertion macros shared by the seed record parser RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SEED_RECORD_STREAM_PARSER_UNIT_DEFINES_SVH
`define SEED_RECORD_STREAM_PARSER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SRSP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("srsp assertion failed");
// next-cycle implication
`define SRSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("srsp assertion failed");
`else
`define SRSP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define SRSP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/srsp_pkg.sv =====
// Shared types, codes and helper functions for the seed record parser.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srsp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'b1;

  // field kinds as reported on the result
  localparam logic [3:0] K_MAGIC     = 4'd0;
  localparam logic [3:0] K_VERSION   = 4'd1;
  localparam logic [3:0] K_CAND      = 4'd2;
  localparam logic [3:0] K_SCHED_CNT = 4'd3;
  localparam logic [3:0] K_MSG_CNT   = 4'd4;
  localparam logic [3:0] K_CALLBACK  = 4'd5;
  localparam logic [3:0] K_THREAD    = 4'd6;
  localparam logic [3:0] K_DELAY     = 4'd7;
  localparam logic [3:0] K_PRE_CNT   = 4'd8;
  localparam logic [3:0] K_ACCESS    = 4'd9;
  localparam logic [3:0] K_YIELD     = 4'd10;
  localparam logic [3:0] K_TOPIC     = 4'd11;
  localparam logic [3:0] K_OFFSET    = 4'd12;
  localparam logic [3:0] K_PAY_LEN   = 4'd13;
  localparam logic [3:0] K_PAYLOAD   = 4'd14;

  // final status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_SHORT_HDR = 4'd1;
  localparam logic [3:0] ST_BAD_MAGIC = 4'd2;
  localparam logic [3:0] ST_BAD_VER   = 4'd3;
  localparam logic [3:0] ST_ZERO_CAND = 4'd4;
  localparam logic [3:0] ST_SHORT_SCH = 4'd5;
  localparam logic [3:0] ST_SHORT_PRE = 4'd6;
  localparam logic [3:0] ST_SHORT_MSG = 4'd7;
  localparam logic [3:0] ST_TRAILING  = 4'd8;
  localparam logic [3:0] ST_NO_SCHED  = 4'd9;

  typedef enum logic [15:0] {
    PH_MAGIC     = 16'h0001,
    PH_VERSION   = 16'h0002,
    PH_CAND      = 16'h0004,
    PH_SCHED_CNT = 16'h0008,
    PH_MSG_CNT   = 16'h0010,
    PH_CALLBACK  = 16'h0020,
    PH_THREAD    = 16'h0040,
    PH_DELAY     = 16'h0080,
    PH_PRE_CNT   = 16'h0100,
    PH_ACCESS    = 16'h0200,
    PH_YIELD     = 16'h0400,
    PH_TOPIC     = 16'h0800,
    PH_OFFSET    = 16'h1000,
    PH_PAY_LEN   = 16'h2000,
    PH_PAYLOAD   = 16'h4000,
    PH_DONE      = 16'h8000
  } phase_t;

  // one result item
  typedef struct packed {
    logic        field_valid;
    logic [3:0]  field_kind;
    logic [31:0] field_value;
    logic        done_res;
    logic [3:0]  status;
  } res_t;

  function automatic logic [3:0] phase_kind(input phase_t ph);
    logic [3:0] k;
    unique case (ph)
      PH_MAGIC:     k = K_MAGIC;
      PH_VERSION:   k = K_VERSION;
      PH_CAND:      k = K_CAND;
      PH_SCHED_CNT: k = K_SCHED_CNT;
      PH_MSG_CNT:   k = K_MSG_CNT;
      PH_CALLBACK:  k = K_CALLBACK;
      PH_THREAD:    k = K_THREAD;
      PH_DELAY:     k = K_DELAY;
      PH_PRE_CNT:   k = K_PRE_CNT;
      PH_ACCESS:    k = K_ACCESS;
      PH_YIELD:     k = K_YIELD;
      PH_TOPIC:     k = K_TOPIC;
      PH_OFFSET:    k = K_OFFSET;
      PH_PAY_LEN:   k = K_PAY_LEN;
      PH_PAYLOAD:   k = K_PAYLOAD;
      default:      k = K_MAGIC;
    endcase
    return k;
  endfunction

  // byte position of the last byte of a field: field length minus one
  function automatic logic [1:0] field_last_pos(input logic [3:0] k);
    logic [1:0] p;
    unique case (k)
      K_MAGIC, K_CAND, K_DELAY, K_YIELD, K_OFFSET: p = 2'd3;
      K_THREAD, K_PRE_CNT, K_PAYLOAD:              p = 2'd0;
      default:                                     p = 2'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/srsp_core.sv =====
// Field assembler and record state machine of the seed record parser.
// Uses srsp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "seed_record_stream_parser_unit_defines.svh"

module srsp_core (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             cfg_we,
  input  wire [srsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [srsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire                             accept,
  input  wire [7:0]                       data_byte,
  input  wire                             last_byte,
  output logic                            res_push,
  output srsp_pkg::res_t                  res
);
  import srsp_pkg::*;

  logic [31:0] expected_magic;
  logic [15:0] expected_version;

  phase_t      phase, phase_next;
  logic [1:0]  byte_in_field, byte_in_field_next;
  logic [31:0] field_accumulator, field_accumulator_next;
  logic [2:0]  header_fault_flags, header_fault_flags_next;
  logic        schedule_total_zero, schedule_total_zero_next;
  logic [15:0] schedules_left, schedules_left_next;
  logic [15:0] messages_left, messages_left_next;
  logic [7:0]  preemptions_left, preemptions_left_next;
  logic [15:0] payload_left, payload_left_next;
  logic [3:0]  sticky_error, sticky_error_next;

  logic [3:0]  kind;
  logic [31:0] merged;
  logic        fld_done;
  logic        fld_valid;
  logic [3:0]  status_val;

  function automatic phase_t after_message(input logic [15:0] msgs);
    return (msgs != 16'd0) ? PH_TOPIC : PH_DONE;
  endfunction

  function automatic phase_t after_entry(input logic [15:0] scheds, input logic [15:0] msgs);
    return (scheds != 16'd0) ? PH_CALLBACK : after_message(msgs);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAGIC:   expected_magic   <= cfg_data;
        REG_VERSION: expected_version <= cfg_data[15:0];
        default:     ;
      endcase
    end
  end

  assign kind     = phase_kind(phase);
  // bytes past the current one are still zero in the accumulator
  assign merged   = field_accumulator | ({24'd0, data_byte} << {byte_in_field, 3'b000});
  assign fld_done = (byte_in_field == field_last_pos(kind));

  always_comb begin
    phase_next               = phase;
    byte_in_field_next       = byte_in_field;
    field_accumulator_next   = field_accumulator;
    header_fault_flags_next  = header_fault_flags;
    schedule_total_zero_next = schedule_total_zero;
    schedules_left_next      = schedules_left;
    messages_left_next       = messages_left;
    preemptions_left_next    = preemptions_left;
    payload_left_next        = payload_left;
    sticky_error_next        = sticky_error;
    fld_valid                = 1'b0;
    status_val               = ST_OK;

    if (sticky_error == ST_OK) begin
      if (phase == PH_DONE) begin
        sticky_error_next = ST_TRAILING;
      end else if (fld_done) begin
        fld_valid              = 1'b1;
        byte_in_field_next     = 2'd0;
        field_accumulator_next = '0;
        unique case (phase)
          PH_MAGIC: begin
            if (merged != expected_magic) header_fault_flags_next[0] = 1'b1;
            phase_next = PH_VERSION;
          end
          PH_VERSION: begin
            if (merged != {16'd0, expected_version}) header_fault_flags_next[1] = 1'b1;
            phase_next = PH_CAND;
          end
          PH_CAND: begin
            if (merged == 32'd0) header_fault_flags_next[2] = 1'b1;
            phase_next = PH_SCHED_CNT;
          end
          PH_SCHED_CNT: begin
            schedules_left_next      = merged[15:0];
            schedule_total_zero_next = (merged[15:0] == 16'd0);
            phase_next               = PH_MSG_CNT;
          end
          PH_MSG_CNT: begin
            messages_left_next = merged[15:0];
            priority if (header_fault_flags[0]) sticky_error_next = ST_BAD_MAGIC;
            else if (header_fault_flags[1])     sticky_error_next = ST_BAD_VER;
            else if (header_fault_flags[2])     sticky_error_next = ST_ZERO_CAND;
            else                                sticky_error_next = ST_OK;
            phase_next = after_entry(schedules_left, merged[15:0]);
          end
          PH_CALLBACK: phase_next = PH_THREAD;
          PH_THREAD:   phase_next = PH_DELAY;
          PH_DELAY:    phase_next = PH_PRE_CNT;
          PH_PRE_CNT: begin
            preemptions_left_next = merged[7:0];
            schedules_left_next   = schedules_left - 16'd1;
            phase_next = (merged[7:0] != 8'd0) ? PH_ACCESS
                       : after_entry(schedules_left - 16'd1, messages_left);
          end
          PH_ACCESS: phase_next = PH_YIELD;
          PH_YIELD: begin
            preemptions_left_next = preemptions_left - 8'd1;
            phase_next = (preemptions_left != 8'd1) ? PH_ACCESS
                       : after_entry(schedules_left, messages_left);
          end
          PH_TOPIC:  phase_next = PH_OFFSET;
          PH_OFFSET: phase_next = PH_PAY_LEN;
          PH_PAY_LEN: begin
            payload_left_next  = merged[15:0];
            messages_left_next = messages_left - 16'd1;
            phase_next = (merged[15:0] != 16'd0) ? PH_PAYLOAD
                       : after_message(messages_left - 16'd1);
          end
          PH_PAYLOAD: begin
            payload_left_next = payload_left - 16'd1;
            phase_next = (payload_left != 16'd1) ? PH_PAYLOAD
                       : after_message(messages_left);
          end
          default: ;
        endcase
      end else begin
        byte_in_field_next     = byte_in_field + 2'd1;
        field_accumulator_next = merged;
      end
    end

    if (last_byte) begin
      // status from the state this byte leaves behind
      priority if (sticky_error_next != ST_OK) status_val = sticky_error_next;
      else if (phase_next == PH_MAGIC || phase_next == PH_VERSION || phase_next == PH_CAND
               || phase_next == PH_SCHED_CNT || phase_next == PH_MSG_CNT)
        status_val = ST_SHORT_HDR;
      else if (phase_next == PH_CALLBACK || phase_next == PH_THREAD
               || phase_next == PH_DELAY || phase_next == PH_PRE_CNT)
        status_val = ST_SHORT_SCH;
      else if (phase_next == PH_ACCESS || phase_next == PH_YIELD)
        status_val = ST_SHORT_PRE;
      else if (phase_next != PH_DONE)
        status_val = ST_SHORT_MSG;
      else if (schedule_total_zero_next)
        status_val = ST_NO_SCHED;
      else
        status_val = ST_OK;

      // restart with the header
      phase_next               = PH_MAGIC;
      byte_in_field_next       = 2'd0;
      field_accumulator_next   = '0;
      header_fault_flags_next  = '0;
      schedule_total_zero_next = 1'b0;
      schedules_left_next      = '0;
      messages_left_next       = '0;
      preemptions_left_next    = '0;
      payload_left_next        = '0;
      sticky_error_next        = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_MAGIC;
      byte_in_field       <= '0;
      field_accumulator   <= '0;
      header_fault_flags  <= '0;
      schedule_total_zero <= 1'b0;
      schedules_left      <= '0;
      messages_left       <= '0;
      preemptions_left    <= '0;
      payload_left        <= '0;
      sticky_error        <= ST_OK;
    end else if (accept) begin
      phase               <= phase_next;
      byte_in_field       <= byte_in_field_next;
      field_accumulator   <= field_accumulator_next;
      header_fault_flags  <= header_fault_flags_next;
      schedule_total_zero <= schedule_total_zero_next;
      schedules_left      <= schedules_left_next;
      messages_left       <= messages_left_next;
      preemptions_left    <= preemptions_left_next;
      payload_left        <= payload_left_next;
      sticky_error        <= sticky_error_next;
    end
  end

  assign res_push        = accept && (fld_valid || last_byte);
  assign res.field_valid = fld_valid;
  assign res.field_kind  = fld_valid ? kind : K_MAGIC;
  assign res.field_value = fld_valid ? merged : 32'd0;
  assign res.done_res    = last_byte;
  assign res.status      = status_val;

  `SRSP_ASSERT_NEXT(a_restart_after_last, clk, rst, accept && last_byte,
    phase == PH_MAGIC && sticky_error == ST_OK && byte_in_field == 2'd0)
  `SRSP_ASSERT_IMPLY(a_swallow_after_error, clk, rst, accept && sticky_error != ST_OK,
    !res.field_valid)
  `SRSP_ASSERT_IMPLY(a_partial_field_clean, clk, rst, byte_in_field != 2'd0,
    sticky_error == ST_OK && phase != PH_DONE)

endmodule

`default_nettype wire

// ===== rtl/srsp_out_buf.sv =====
// Two-entry result buffer (output register plus skid slot) of the parser.
// Uses srsp_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "seed_record_stream_parser_unit_defines.svh"

module srsp_out_buf (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  srsp_pkg::res_t  push_res,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  output srsp_pkg::res_t  out_res
);
  import srsp_pkg::*;

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;
  logic pop;

  assign pop      = main_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (push) begin
        main_valid <= 1'b1;
      end else begin
        main_valid <= skid_valid;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid) skid_valid <= 1'b1;
      else            main_valid <= 1'b1;
    end
  end

  // payload: push only happens while the skid slot is empty
  always_ff @(posedge clk) begin
    if (pop) begin
      main_res <= push ? push_res : skid_res;
    end else if (push) begin
      if (main_valid) skid_res <= push_res;
      else            main_res <= push_res;
    end
  end

  assign out_valid = main_valid;
  assign out_res   = main_res;

  `SRSP_ASSERT_IMPLY(a_skid_behind_main, clk, rst, skid_valid, main_valid)
  `SRSP_ASSERT_IMPLY(a_no_push_when_full, clk, rst, skid_valid, !push)
  `SRSP_ASSERT_NEXT(a_fill_skid, clk, rst, push && main_valid && !out_ready, skid_valid)

endmodule

`default_nettype wire

// ===== rtl/seed_record_stream_parser_unit.sv =====
// Top level of the seed record stream parser.
// Uses srsp_pkg, srsp_core and srsp_out_buf.
//
// channel  | dir | handshake              | payload
// ---------+-----+------------------------+-------------------------------------------
// s_axis   | in  | tvalid/tready          | tdata[7:0] data_byte, tlast last_byte
// m_axis   | out | tvalid/tready          | tdata value/status, tuser valid/kind, tlast
// cfg      | in  | cfg_we (no wait)       | cfg_index register, cfg_data value
//
// One byte is accepted per cycle while s_axis_tready is high; the field state
// machine is combinational and any result is registered in the output buffer.
// A two-entry output buffer keeps input flowing while one result waits;
// s_axis_tready drops only when both entries are full.
// Bytes that finish no field and are not last produce no result item.
// rst is synchronous and active high; config registers reset to zero.
`timescale 1ns / 1ps
`default_nettype none

module seed_record_stream_parser_unit (
  input  wire                             clk,
  input  wire                             rst,
  // configuration writes: index 0 expected magic, index 1 expected version
  input  wire                             cfg_we,
  input  wire [srsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [srsp_pkg::CFG_DATA_W-1:0]  cfg_data,
  // record bytes
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire [7:0]                       s_axis_tdata,   // [7:0] data_byte
  input  wire                             s_axis_tlast,   // last_byte
  // result items
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [39:0]                     m_axis_tdata,   // [31:0] field_value,
                                                          // [35:32] status, [39:36] zero
  output logic [4:0]                      m_axis_tuser,   // [0] field_valid,
                                                          // [4:1] field_kind
  output logic                            m_axis_tlast    // done_res
);
  import srsp_pkg::*;

  logic accept;
  logic res_push;
  res_t core_res;
  res_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  srsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .res_push  (res_push),
    .res       (core_res)
  );

  srsp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_res  (core_res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.status, out_res.field_value};
  assign m_axis_tuser = {out_res.field_kind, out_res.field_valid};
  assign m_axis_tlast = out_res.done_res;

endmodule

`default_nettype wire
